>>> hdl/bba_pkg.sv
// Shared types and constants of the multi-block bump allocator.
package bba_pkg;

   localparam int unsigned SIZE_W = 32;
   localparam int unsigned BLK_FIELD_W = 4;
   localparam logic [SIZE_W-1:0] MIN_BLOCK_RESET = 32'd1048576;

   typedef logic [1:0] func_type;
   localparam func_type FUNC_ALLOC = 2'd0;
   localparam func_type FUNC_RESIZE = 2'd1;
   localparam func_type FUNC_FREE_ALL = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STAT_OK = 2'd0;
   localparam status_type STAT_COPY = 2'd1;
   localparam status_type STAT_FULL = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_OLD,
      S_CHK_OLD,
      S_SCAN,
      S_SWEEP,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type status;
      logic [BLK_FIELD_W-1:0] block;
      logic [SIZE_W-1:0] offset;
   } result_type;

   typedef struct packed {
      logic load;
      result_type data;
   } out_ctl_type;

endpackage

>>> hdl/bba_req_if.sv
// Request channel of the allocator: valid, ready and the request payload.
interface bba_req_if;
   logic valid;
   logic ready;
   logic [1:0] func;
   logic [31:0] req_size;
   logic [31:0] prev_size;
   logic [3:0] old_block;
   logic [31:0] old_offset;

   modport source (output valid, func, req_size, prev_size, old_block, old_offset,
                   input ready);
   modport sink (input valid, func, req_size, prev_size, old_block, old_offset,
                 output ready);
endinterface

>>> hdl/bba_rsp_if.sv
// Response channel of the allocator: valid, ready and the grant payload.
interface bba_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [3:0] result_block;
   logic [31:0] result_offset;

   modport source (output valid, status, result_block, result_offset, input ready);
   modport sink (input valid, status, result_block, result_offset, output ready);
endinterface

>>> hdl/multi_block_bump_allocator.sv
// An allocate scans the open blocks in turn; a resize with a nonzero old size first reads and
// checks its old block, and then scans only if it cannot stay in place; free-all sweeps the
// open blocks. One transaction is in work at a time; the next request is accepted the cycle
// after the response is loaded, which waits while the last one is unread.
// Reset clears the open-block count and restores min_block_size to 1 MiB; the
// memories are not cleared, since an entry is always written when its block opens.
module multi_block_bump_allocator #(
   parameter int unsigned MAX_BLOCKS = 16
) (
   input  logic clock,
   input  logic reset,
   bba_req_if.sink req_bus,
   bba_rsp_if.source rsp_bus,
   input  logic csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import bba_pkg::*;

   localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic [AW-1:0] ram_rd_addr, ram_wr_addr;
   logic cap_we, fill_we;
   logic [SIZE_W-1:0] cap_wr_data, cap_rd_data, fill_wr_data, fill_rd_data;
   out_ctl_type out_ctl;
   logic out_free;

   bba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .ram_rd_addr(ram_rd_addr),
      .ram_wr_addr(ram_wr_addr),
      .cap_we(cap_we),
      .cap_wr_data(cap_wr_data),
      .cap_rd_data(cap_rd_data),
      .fill_we(fill_we),
      .fill_wr_data(fill_wr_data),
      .fill_rd_data(fill_rd_data),
      .out_ctl(out_ctl),
      .out_free(out_free)
   );

   bba_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_BLOCKS)) u_cap_ram (
      .clock(clock),
      .wr_en(cap_we),
      .wr_addr(ram_wr_addr),
      .wr_data(cap_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(cap_rd_data)
   );

   bba_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_BLOCKS)) u_fill_ram (
      .clock(clock),
      .wr_en(fill_we),
      .wr_addr(ram_wr_addr),
      .wr_data(fill_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(fill_rd_data)
   );

   bba_out_reg u_out_reg (
      .clock(clock),
      .reset(reset),
      .out_ctl(out_ctl),
      .out_free(out_free),
      .rsp_bus(rsp_bus)
   );

endmodule

>>> hdl/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bba_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bba_out_reg.sv
// Output register that holds one response until the consumer takes it.
module bba_out_reg (
   input  logic clock,
   input  logic reset,
   input  bba_pkg::out_ctl_type out_ctl,
   output logic out_free,
   bba_rsp_if.source rsp_bus
);
   import bba_pkg::*;

   logic valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (out_ctl.load) begin
         valid_in = 1'b1;
         data_in = out_ctl.data;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.status = data_ff.status;
   assign rsp_bus.result_block = data_ff.block;
   assign rsp_bus.result_offset = data_ff.offset;

endmodule

>>> hdl/bba_ctrl.sv
// Allocator sequencer: block scan, resize check, free-all sweep and block opening.
module bba_ctrl #(
   parameter int unsigned MAX_BLOCKS = 16
) (
   input  logic clock,
   input  logic reset,
   bba_req_if.sink req_bus,
   input  logic csr_wr_en,
   input  logic [bba_pkg::SIZE_W-1:0] csr_wr_data,
   output logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] ram_rd_addr,
   output logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] ram_wr_addr,
   output logic cap_we,
   output logic [bba_pkg::SIZE_W-1:0] cap_wr_data,
   input  logic [bba_pkg::SIZE_W-1:0] cap_rd_data,
   output logic fill_we,
   output logic [bba_pkg::SIZE_W-1:0] fill_wr_data,
   input  logic [bba_pkg::SIZE_W-1:0] fill_rd_data,
   output bba_pkg::out_ctl_type out_ctl,
   input  logic out_free
);
   import bba_pkg::*;

   localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned CMP_W = (CNT_W > BLK_FIELD_W) ? CNT_W : BLK_FIELD_W;

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] min_size_ff, min_size_in;
   logic [CNT_W-1:0] open_ff, open_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic released_ff, released_in;
   logic copy_ff, copy_in;
   logic [SIZE_W-1:0] saved_fill_ff, saved_fill_in;
   result_type res_ff, res_in;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] prev_size_ff, prev_size_in;
   logic [BLK_FIELD_W-1:0] old_block_ff, old_block_in;
   logic [SIZE_W-1:0] old_offset_ff, old_offset_in;

   logic accept;
   logic old_in_range, old_is_last, old_fits;
   logic [SIZE_W:0] old_end;
   logic scan_hit, scan_more, arena_full;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept = req_bus.valid && req_bus.ready;

   // Resize check against the entry of the old block.
   assign old_in_range = CMP_W'(old_block_ff) < CMP_W'(open_ff);
   assign old_end = {1'b0, old_offset_ff} + {1'b0, prev_size_ff};
   assign old_is_last = old_in_range && (old_offset_ff < cap_rd_data) &&
                        (old_end == {1'b0, fill_rd_data});
   assign old_fits = size_ff <= (cap_rd_data - old_offset_ff);

   // The room test wraps like unsigned 32-bit arithmetic.
   assign scan_hit = chk_vld_ff && (size_ff <= (cap_rd_data - fill_rd_data));
   assign scan_more = idx_ff < open_ff;
   assign arena_full = open_ff == CNT_W'(MAX_BLOCKS);

   always_comb begin
      state_in = state_ff;
      min_size_in = csr_wr_en ? csr_wr_data : min_size_ff;
      open_in = open_ff;
      idx_in = idx_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      released_in = released_ff;
      copy_in = copy_ff;
      saved_fill_in = saved_fill_ff;
      res_in = res_ff;
      size_in = size_ff;
      prev_size_in = prev_size_ff;
      old_block_in = old_block_ff;
      old_offset_in = old_offset_ff;

      ram_rd_addr = idx_ff[AW-1:0];
      ram_wr_addr = AW'(old_block_ff);
      cap_we = 1'b0;
      cap_wr_data = size_ff;
      fill_we = 1'b0;
      fill_wr_data = size_ff;
      out_ctl.load = 1'b0;
      out_ctl.data = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               size_in = req_bus.req_size;
               prev_size_in = req_bus.prev_size;
               old_block_in = req_bus.old_block;
               old_offset_in = req_bus.old_offset;
               idx_in = '0;
               chk_vld_in = 1'b0;
               released_in = 1'b0;
               copy_in = 1'b0;
               if (req_bus.func == FUNC_ALLOC ||
                   (req_bus.func == FUNC_RESIZE && req_bus.prev_size == '0)) begin
                  state_in = S_SCAN;
               end else if (req_bus.func == FUNC_RESIZE) begin
                  state_in = S_RD_OLD;
               end else if (req_bus.func == FUNC_FREE_ALL) begin
                  state_in = S_SWEEP;
               end else begin
                  res_in = '{status: STAT_OK, block: '0, offset: '0};
                  state_in = S_DONE;
               end
            end
         end
         S_RD_OLD: begin
            ram_rd_addr = AW'(old_block_ff);
            state_in = S_CHK_OLD;
         end
         S_CHK_OLD: begin
            ram_wr_addr = AW'(old_block_ff);
            if (old_is_last && old_fits) begin
               fill_we = 1'b1;
               fill_wr_data = old_offset_ff + size_ff;
               res_in = '{status: STAT_OK, block: old_block_ff, offset: old_offset_ff};
               state_in = S_DONE;
            end else begin
               // Release the old space if it was last; the scan reads it back.
               if (old_is_last) begin
                  fill_we = 1'b1;
                  fill_wr_data = old_offset_ff;
               end
               released_in = old_is_last;
               saved_fill_in = fill_rd_data;
               copy_in = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               ram_wr_addr = chk_idx_ff;
               fill_we = 1'b1;
               fill_wr_data = fill_rd_data + size_ff;
               res_in = '{status: copy_ff ? STAT_COPY : STAT_OK,
                          block: BLK_FIELD_W'(chk_idx_ff), offset: fill_rd_data};
               state_in = S_DONE;
            end else if (scan_more) begin
               idx_in = idx_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff[AW-1:0];
            end else if (arena_full) begin
               // No room anywhere: put back a released allocation.
               ram_wr_addr = AW'(old_block_ff);
               fill_we = released_ff;
               fill_wr_data = saved_fill_ff;
               res_in = '{status: STAT_FULL, block: '0, offset: '0};
               state_in = S_DONE;
            end else begin
               ram_wr_addr = open_ff[AW-1:0];
               cap_we = 1'b1;
               cap_wr_data = (size_ff > min_size_ff) ? size_ff : min_size_ff;
               fill_we = 1'b1;
               fill_wr_data = size_ff;
               open_in = open_ff + 1'b1;
               res_in = '{status: copy_ff ? STAT_COPY : STAT_OK,
                          block: BLK_FIELD_W'(open_ff), offset: '0};
               state_in = S_DONE;
            end
         end
         S_SWEEP: begin
            if (scan_more) begin
               ram_wr_addr = idx_ff[AW-1:0];
               fill_we = 1'b1;
               fill_wr_data = '0;
               idx_in = idx_ff + 1'b1;
            end else begin
               res_in = '{status: STAT_OK, block: '0, offset: '0};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_ctl.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         min_size_ff <= MIN_BLOCK_RESET;
         open_ff <= '0;
         chk_vld_ff <= 1'b0;
         released_ff <= 1'b0;
         copy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_size_ff <= min_size_in;
         open_ff <= open_in;
         chk_vld_ff <= chk_vld_in;
         released_ff <= released_in;
         copy_ff <= copy_in;
      end
      idx_ff <= idx_in;
      chk_idx_ff <= chk_idx_in;
      saved_fill_ff <= saved_fill_in;
      res_ff <= res_in;
      size_ff <= size_in;
      prev_size_ff <= prev_size_in;
      old_block_ff <= old_block_in;
      old_offset_ff <= old_offset_in;
   end

endmodule

>>> test/multi_block_bump_allocator_checker.sv
// Checker for the bump allocator: predicts each grant and compares every response.
`timescale 1ns / 100ps

module multi_block_bump_allocator_checker (
   input  logic clock,
   input  logic reset,
   bba_req_if req_bus,
   bba_rsp_if rsp_bus,
   input  logic csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int unsigned fail_count,
   output int unsigned outstanding
);
   import bba_pkg::*;

   localparam int unsigned MAX_BLOCKS = 16;

   logic [31:0] capacity [MAX_BLOCKS];
   logic [31:0] fill [MAX_BLOCKS];
   int unsigned open_count;
   logic [31:0] min_size;
   result_type grants_due [$];

   // Bump the first open block with enough room, or open a new block if none fits.
   function automatic bit claim_space(input logic [31:0] size, output logic [3:0] blk,
                                      output logic [31:0] off);
      blk = '0;
      off = '0;
      for (int i = 0; i < open_count; i++) begin
         if (size <= capacity[i] - fill[i]) begin
            blk = 4'(i);
            off = fill[i];
            fill[i] = fill[i] + size;
            return 1'b1;
         end
      end
      if (open_count >= MAX_BLOCKS) begin
         return 1'b0;
      end
      capacity[open_count] = (size > min_size) ? size : min_size;
      fill[open_count] = size;
      blk = 4'(open_count);
      open_count++;
      return 1'b1;
   endfunction

   function automatic result_type predict_grant(input func_type func, input logic [31:0] size,
                                                input logic [31:0] osz, input logic [3:0] oblk,
                                                input logic [31:0] ooff);
      result_type res;
      bit is_last;
      logic [31:0] saved;
      res = '0;
      res.status = STAT_OK;
      if (func == FUNC_ALLOC || (func == FUNC_RESIZE && osz == '0)) begin
         if (!claim_space(size, res.block, res.offset)) begin
            res = '0;
            res.status = STAT_FULL;
         end
      end else if (func == FUNC_RESIZE) begin
         is_last = 1'b0;
         if (oblk < open_count) begin
            is_last = (ooff < capacity[oblk]) &&
                      ({1'b0, ooff} + {1'b0, osz} == {1'b0, fill[oblk]});
         end
         if (is_last && size <= capacity[oblk] - ooff) begin
            fill[oblk] = ooff + size;
            res.block = oblk;
            res.offset = ooff;
         end else begin
            saved = '0;
            // A last allocation is freed before the search, so its block may take it again.
            if (is_last) begin
               saved = fill[oblk];
               fill[oblk] = ooff;
            end
            if (claim_space(size, res.block, res.offset)) begin
               res.status = STAT_COPY;
            end else begin
               if (is_last) begin
                  fill[oblk] = saved;
               end
               res = '0;
               res.status = STAT_FULL;
            end
         end
      end else if (func == FUNC_FREE_ALL) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            fill[i] = '0;
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type due;
      if (reset) begin
         open_count = 0;
         min_size = MIN_BLOCK_RESET;
         fail_count = 0;
         grants_due.delete();
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            capacity[i] = '0;
            fill[i] = '0;
         end
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            min_size = csr_wr_data;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (grants_due.size() == 0) begin
               $error("unexpected response transaction: status %0d block %0d offset %0h",
                      rsp_bus.status, rsp_bus.result_block, rsp_bus.result_offset);
               fail_count++;
            end else begin
               due = grants_due.pop_front();
               check_field("status", 32'(due.status), 32'(rsp_bus.status));
               check_field("result_block", 32'(due.block), 32'(rsp_bus.result_block));
               check_field("result_offset", due.offset, rsp_bus.result_offset);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            grants_due.push_back(predict_grant(req_bus.func, req_bus.req_size, req_bus.prev_size,
                                               req_bus.old_block, req_bus.old_offset));
         end
         outstanding <= grants_due.size();
      end
   end

endmodule

>>> test/multi_block_bump_allocator_tb.sv
// Top-level testbench of the bump allocator: stimulus, reset, clock and verdict.
`timescale 1ns / 100ps

module multi_block_bump_allocator_tb;
   import bba_pkg::*;

   localparam func_type FUNC_UNUSED = 2'd3;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES = 30;
   localparam int unsigned PHASE_ITEMS = 135;
   localparam int unsigned LIVE_DEPTH = 8;

   typedef struct {
      func_type func;
      logic [31:0] size;
   } issued_type;

   typedef struct {
      logic [3:0] block;
      logic [31:0] offset;
      logic [31:0] size;
   } grant_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [31:0] csr_wr_data;
   bit steady;
   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned idle_cycles;
   issued_type issued_q [$];
   grant_type live_q [$];

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();

   multi_block_bump_allocator uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   multi_block_bump_allocator_checker grant_check (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 12);
   end

   // Track live grants so that most resizes name a real allocation. Sampling at the
   // falling edge sees exactly the transactions the next rising edge will accept.
   always @(negedge clock) begin
      issued_type issued;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            issued_q.push_back('{req_bus.func, req_bus.req_size});
         end
         if (rsp_bus.valid && rsp_bus.ready && issued_q.size() != 0) begin
            issued = issued_q.pop_front();
            if (issued.func == FUNC_FREE_ALL) begin
               live_q.delete();
            end else if ((issued.func == FUNC_ALLOC || issued.func == FUNC_RESIZE) &&
                         rsp_bus.status != STAT_FULL) begin
               live_q.push_back('{rsp_bus.result_block, rsp_bus.result_offset, issued.size});
               if (live_q.size() > LIVE_DEPTH) begin
                  void'(live_q.pop_front());
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_block_bump_allocator_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(input func_type func, input logic [31:0] size,
                            input logic [31:0] osz, input logic [3:0] oblk,
                            input logic [31:0] ooff);
      while (!steady && $urandom_range(99) < 12) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.req_size <= size;
      req_bus.prev_size <= osz;
      req_bus.old_block <= oblk;
      req_bus.old_offset <= ooff;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Hold the sender until every response has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_min_size(input logic [31:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_size();
      int unsigned k;
      k = $urandom_range(99);
      if (k < 40) begin
         return $urandom_range(4095);
      end else if (k < 70) begin
         return $urandom_range(1 << 20);
      end else if (k < 85) begin
         return $urandom_range(1 << 24);
      end else if (k < 95) begin
         return $urandom;
      end
      return ($urandom_range(1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
   endfunction

   task automatic send_random();
      int unsigned pick;
      int unsigned idx;
      grant_type live;
      pick = $urandom_range(99);
      if (pick < 45) begin
         send_item(FUNC_ALLOC, pick_size(), $urandom, 4'($urandom), $urandom);
      end else if (pick < 85) begin
         if (live_q.size() != 0 && $urandom_range(99) < 80) begin
            idx = ($urandom_range(1) == 0) ? live_q.size() - 1 : $urandom_range(live_q.size() - 1);
            live = live_q[idx];
            case ($urandom_range(3))
               0: send_item(FUNC_RESIZE, live.size + $urandom_range(4096), live.size,
                            live.block, live.offset);
               1: send_item(FUNC_RESIZE, $urandom_range(live.size), live.size,
                            live.block, live.offset);
               2: send_item(FUNC_RESIZE, pick_size(), live.size, live.block, live.offset);
               default: send_item(FUNC_RESIZE, pick_size(), live.size + 1, live.block,
                                  live.offset);
            endcase
         end else begin
            send_item(FUNC_RESIZE, pick_size(), ($urandom_range(3) == 0) ? 32'd0 : $urandom,
                      4'($urandom), $urandom);
         end
      end else if (pick < 93) begin
         send_item(FUNC_FREE_ALL, $urandom, $urandom, 4'($urandom), $urandom);
      end else if (pick < 96) begin
         send_item(FUNC_UNUSED, $urandom, $urandom, 4'($urandom), $urandom);
      end else begin
         send_item(FUNC_ALLOC, pick_size(), '0, '0, '0);
      end
   endtask

   task automatic run_phase(input bit with_quiet_stretch);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         steady <= with_quiet_stretch && n >= 30 && n < 100;
         send_random();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      steady = 1'b0;
      rsp_bus.ready = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_ALLOC;
      req_bus.req_size = '0;
      req_bus.prev_size = '0;
      req_bus.old_block = '0;
      req_bus.old_offset = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset block size of 1 MiB.
      send_item(FUNC_ALLOC, 32'd0, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
      send_item(FUNC_ALLOC, 32'd100, '0, '0, '0);
      send_item(FUNC_RESIZE, 32'd300, 32'd100, 4'd0, 32'd0);       // last one, grows in place
      send_item(FUNC_RESIZE, 32'd50, 32'd0, 4'd0, 32'd0);          // no old allocation
      send_item(FUNC_RESIZE, 32'd64, 32'd100, 4'd0, 32'd0);        // not the last one
      send_item(FUNC_RESIZE, 32'd64, 32'd64, 4'hF, 32'd350);       // block never opened
      send_item(FUNC_RESIZE, 32'd8, 32'd64, 4'd0, 32'hFFFF_FFFF);  // offset past the block
      send_item(FUNC_RESIZE, 32'd2097152, 32'd8, 4'd0, 32'd478);   // released, moves elsewhere
      send_item(FUNC_ALLOC, 32'd1000, '0, '0, '0);
      send_item(FUNC_RESIZE, 32'd1048098, 32'd1000, 4'd0, 32'd478); // exactly fills the block
      send_item(FUNC_FREE_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
      send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
      send_item(FUNC_ALLOC, 32'd1048576, '0, '0, '0);
      run_phase(1'b0);

      write_min_size(32'd1);
      run_phase(1'b1);

      write_min_size($urandom_range(1 << 24, 1 << 12));
      run_phase(1'b0);

      write_min_size(32'hFFFF_FFFF);
      run_phase(1'b0);

      // Flood with the largest size so every block opens and the arena runs out.
      send_item(FUNC_FREE_ALL, '0, '0, '0, '0);
      repeat (17) send_item(FUNC_ALLOC, 32'hFFFF_FFFF, '0, '0, '0);
      send_item(FUNC_RESIZE, 32'hFFFF_FFFF, 32'd1, 4'd0, 32'd0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("multi_block_bump_allocator_tb: PASS");
      end else begin
         $display("multi_block_bump_allocator_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> multi_block_bump_allocator.f
hdl/bba_pkg.sv
hdl/bba_req_if.sv
hdl/bba_rsp_if.sv
hdl/bba_ram.sv
hdl/bba_out_reg.sv
hdl/bba_ctrl.sv
hdl/multi_block_bump_allocator.sv
test/multi_block_bump_allocator_checker.sv
test/multi_block_bump_allocator_tb.sv
